>>> src/cmep_pkg.sv
// shared types and codes for the compact midi event parser
// parse phases, event kinds, error codes and event type numbers; no dependencies
package cmep_pkg;

  typedef enum logic [8:0] {
    PH_TYPE    = 9'b000000001,
    PH_PREFIX  = 9'b000000010,
    PH_VAL1    = 9'b000000100,
    PH_VAL2    = 9'b000001000,
    PH_SIZE0   = 9'b000010000,
    PH_SIZE1   = 9'b000100000,
    PH_PAYLOAD = 9'b001000000,
    PH_END0    = 9'b010000000,
    PH_END1    = 9'b100000000
  } phase_t;

  typedef logic [3:0] kind_t;
  typedef logic [3:0] err_t;
  typedef logic [3:0] evtype_t;

  localparam kind_t K_DELTA   = 4'd0;
  localparam kind_t K_NOTEOFF = 4'd1;
  localparam kind_t K_NOTEON  = 4'd2;
  localparam kind_t K_CONTROL = 4'd3;
  localparam kind_t K_AFTER   = 4'd4;
  localparam kind_t K_BEND    = 4'd5;
  localparam kind_t K_PAYLOAD = 4'd6;
  localparam kind_t K_END     = 4'd7;
  localparam kind_t K_RXOFF   = 4'd8;
  localparam kind_t K_RXON    = 4'd9;
  localparam kind_t K_ERROR   = 4'd10;

  localparam err_t E_NONE        = 4'd0;
  localparam err_t E_PREFIX_TYPE = 4'd1;
  localparam err_t E_PREFIX_BYTE = 4'd2;
  localparam err_t E_NO_FLAG     = 4'd3;
  localparam err_t E_FLAG_SET    = 4'd4;
  localparam err_t E_BAD_SIZE    = 4'd5;
  localparam err_t E_BAD_END     = 4'd6;
  localparam err_t E_UNKNOWN     = 4'd7;
  localparam err_t E_TRUNCATED   = 4'd8;

  localparam evtype_t T_NOTEOFF = 4'd0;
  localparam evtype_t T_NOTEON  = 4'd1;
  localparam evtype_t T_CONTROL = 4'd3;
  localparam evtype_t T_AFTER   = 4'd5;
  localparam evtype_t T_BEND    = 4'd6;
  localparam evtype_t T_META    = 4'd9;
  localparam evtype_t T_RXOFF   = 4'd12;
  localparam evtype_t T_RXON    = 4'd13;

  localparam logic [7:0] B_PAYLOAD_MARK = 8'h7E;
  localparam logic [7:0] B_END_MARK     = 8'h2F;

endpackage

>>> src/compact_midi_event_parser.sv
// compact midi event parser: top level, one track byte in, at most one event out
// depends on cmep_pkg for phases, event kinds, error codes and type numbers
//
// usage:
//   input channel: in_data_byte with in_track_start / in_last_byte flags, one
//   byte per transaction (in_valid high and in_stall low at a rising edge).
//   output channel: one event per transaction on out_* fields, taken when
//   out_valid is high and out_stall low.
//   config: cfg_wr_en / cfg_wr_data set the two-byte field order
//   (0 little endian, 1 big endian); write only while the block is idle.
// timing:
//   an accepted byte goes into the input register; its event, if any, is
//   loaded into the output register when the byte leaves the input register.
//   throughput is one byte per cycle while in_stall is low, set by the single
//   parse step between the input register and the output register.
// reset (rst_n low, synchronous): parser waits for an event type byte, no
//   track is finished, both registers are empty, byte order is little endian.
// stall: a held result blocks only bytes that would produce a new result;
//   the input register then holds and in_stall goes high.
module compact_midi_event_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_track_start,
  input  logic                 in_last_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output cmep_pkg::kind_t      out_event_kind,
  output logic [7:0]           out_first_value,
  output logic [6:0]           out_second_value,
  output logic signed [13:0]   out_bend_amount,
  output logic [31:0]          out_payload_word,
  output logic [2:0]           out_payload_count,
  output cmep_pkg::err_t       out_error_code,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data
);
  import cmep_pkg::*;

  logic        big_endian_r;

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_start_r;
  logic        s1_last_r;

  phase_t      phase_r, phase_nxt, phase_cur;
  evtype_t     type_r, type_nxt;
  logic [7:0]  held_r, held_nxt;
  logic        size4_r, size4_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [31:0] accum_r, accum_nxt;
  logic        done_r, done_nxt, done_cur;

  logic        res_v;
  kind_t       res_kind;
  logic [7:0]  res_v1;
  logic [6:0]  res_v2;
  logic [13:0] res_bend;
  logic [31:0] res_word;
  logic [2:0]  res_cnt;
  err_t        res_err;

  logic [15:0] size_word;
  logic [31:0] word_tmp;
  logic        adv;

  logic                out_valid_r;
  kind_t               out_kind_r;
  logic [7:0]          out_v1_r;
  logic [6:0]          out_v2_r;
  logic signed [13:0]  out_bend_r;
  logic [31:0]         out_word_r;
  logic [2:0]          out_cnt_r;
  err_t                out_err_r;

  assign adv      = s1_valid_r && (!res_v || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      big_endian_r <= 1'b0;
    end else if (cfg_wr_en) begin
      big_endian_r <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!s1_valid_r || adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if ((!s1_valid_r || adv) && in_valid) begin
      s1_byte_r  <= in_data_byte;
      s1_start_r <= in_track_start;
      s1_last_r  <= in_last_byte;
    end
  end

  // parse step
  always_comb begin
    phase_cur = s1_start_r ? PH_TYPE : phase_r;
    done_cur  = s1_start_r ? 1'b0 : done_r;
    phase_nxt = phase_cur;
    done_nxt  = done_cur;
    type_nxt  = type_r;
    held_nxt  = held_r;
    size4_nxt = size4_r;
    idx_nxt   = idx_r;
    accum_nxt = accum_r;
    res_v     = 1'b0;
    res_kind  = K_DELTA;
    res_v1    = 8'd0;
    res_v2    = 7'd0;
    res_bend  = 14'd0;
    res_word  = 32'd0;
    res_cnt   = 3'd0;
    res_err   = E_NONE;
    size_word = big_endian_r ? {held_r, s1_byte_r} : {s1_byte_r, held_r};
    word_tmp  = accum_r;
    word_tmp[{idx_r, 3'b000} +: 8] = s1_byte_r;

    if (!done_cur) begin
      case (phase_cur)
        PH_TYPE: begin
          if (s1_byte_r[7]) begin
            res_v    = 1'b1;
            res_kind = K_DELTA;
            res_v1   = {1'b0, s1_byte_r[6:0]};
          end else if (s1_byte_r[6]) begin
            if (s1_byte_r inside {8'h40, 8'h41, 8'h43, 8'h46}) begin
              type_nxt  = s1_byte_r[3:0];
              phase_nxt = PH_PREFIX;
            end else begin
              res_v    = 1'b1;
              res_kind = K_ERROR;
              res_err  = E_PREFIX_TYPE;
            end
          end else if (s1_byte_r inside {8'd0, 8'd1, 8'd3, 8'd5, 8'd6, 8'd9, 8'd12, 8'd13})
          begin
            type_nxt  = s1_byte_r[3:0];
            phase_nxt = PH_VAL1;
          end else begin
            res_v    = 1'b1;
            res_kind = K_ERROR;
            res_err  = E_UNKNOWN;
          end
        end
        PH_PREFIX: begin
          if (s1_byte_r inside {[8'h08:8'h0F], [8'h71:8'h78]}) begin
            phase_nxt = PH_VAL1;
          end else begin
            res_v    = 1'b1;
            res_kind = K_ERROR;
            res_err  = E_PREFIX_BYTE;
          end
        end
        PH_VAL1: begin
          case (type_r)
            T_CONTROL, T_BEND: begin
              if (s1_byte_r[7]) begin
                res_v    = 1'b1;
                res_kind = K_ERROR;
                res_err  = E_FLAG_SET;
              end else begin
                held_nxt  = s1_byte_r;
                phase_nxt = PH_VAL2;
              end
            end
            T_AFTER: begin
              res_v = 1'b1;
              if (!s1_byte_r[7]) begin
                res_kind = K_ERROR;
                res_err  = E_NO_FLAG;
              end else begin
                res_kind = K_AFTER;
                res_v1   = {1'b0, s1_byte_r[6:0]};
              end
            end
            T_META: begin
              if (s1_byte_r == B_PAYLOAD_MARK) begin
                phase_nxt = PH_SIZE0;
              end else if (s1_byte_r == B_END_MARK) begin
                phase_nxt = PH_END0;
              end else begin
                res_v    = 1'b1;
                res_kind = K_ERROR;
                res_err  = E_BAD_END;
              end
            end
            default: begin
              held_nxt  = s1_byte_r;
              phase_nxt = PH_VAL2;
            end
          endcase
        end
        PH_VAL2: begin
          res_v = 1'b1;
          if (!s1_byte_r[7]) begin
            res_kind = K_ERROR;
            res_err  = E_NO_FLAG;
          end else if (type_r == T_BEND) begin
            // subtracting 8192 from a 14-bit value flips its top bit
            res_kind = K_BEND;
            res_bend = {~s1_byte_r[6], s1_byte_r[5:0], held_r[6:0]};
          end else begin
            res_v1 = held_r;
            res_v2 = s1_byte_r[6:0];
            case (type_r)
              T_NOTEOFF: res_kind = K_NOTEOFF;
              T_NOTEON:  res_kind = K_NOTEON;
              T_CONTROL: res_kind = K_CONTROL;
              T_RXOFF:   res_kind = K_RXOFF;
              default:   res_kind = K_RXON;
            endcase
          end
        end
        PH_SIZE0: begin
          held_nxt  = s1_byte_r;
          phase_nxt = PH_SIZE1;
        end
        PH_SIZE1: begin
          if (size_word == 16'd2 || size_word == 16'd4) begin
            size4_nxt = size_word[2];
            idx_nxt   = 2'd0;
            accum_nxt = 32'd0;
            phase_nxt = PH_PAYLOAD;
          end else begin
            res_v    = 1'b1;
            res_kind = K_ERROR;
            res_err  = E_BAD_SIZE;
          end
        end
        PH_PAYLOAD: begin
          if (idx_r == (size4_r ? 2'd3 : 2'd1)) begin
            res_v    = 1'b1;
            res_kind = K_PAYLOAD;
            res_word = word_tmp;
            res_cnt  = size4_r ? 3'd4 : 3'd2;
          end else begin
            accum_nxt = word_tmp;
            idx_nxt   = idx_r + 2'd1;
          end
        end
        PH_END0: begin
          if (s1_byte_r != 8'd0) begin
            res_v    = 1'b1;
            res_kind = K_ERROR;
            res_err  = E_BAD_END;
          end else begin
            phase_nxt = PH_END1;
          end
        end
        PH_END1: begin
          res_v = 1'b1;
          if (s1_byte_r != 8'd0) begin
            res_kind = K_ERROR;
            res_err  = E_BAD_END;
          end else begin
            res_kind = K_END;
          end
        end
        default: begin
          res_v    = 1'b1;
          res_kind = K_ERROR;
          res_err  = E_UNKNOWN;
        end
      endcase

      if (s1_last_r) begin
        if (!res_v) begin
          res_v    = 1'b1;
          res_kind = K_ERROR;
          res_err  = E_TRUNCATED;
        end
        done_nxt = 1'b1;
      end

      if (res_v) begin
        phase_nxt = PH_TYPE;
        if (res_kind == K_ERROR || res_kind == K_END) begin
          done_nxt = 1'b1;
        end
      end
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TYPE;
      type_r  <= T_NOTEOFF;
      done_r  <= 1'b0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      type_r  <= type_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      held_r  <= held_nxt;
      size4_r <= size4_nxt;
      idx_r   <= idx_nxt;
      accum_r <= accum_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && res_v) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_v) begin
      out_kind_r <= res_kind;
      out_v1_r   <= res_v1;
      out_v2_r   <= res_v2;
      out_bend_r <= $signed(res_bend);
      out_word_r <= res_word;
      out_cnt_r  <= res_cnt;
      out_err_r  <= res_err;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_kind    = out_kind_r;
  assign out_first_value   = out_v1_r;
  assign out_second_value  = out_v2_r;
  assign out_bend_amount   = out_bend_r;
  assign out_payload_word  = out_word_r;
  assign out_payload_count = out_cnt_r;
  assign out_error_code    = out_err_r;

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with empty input register");

  a_new_result_from_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r && out_stall)) |-> $past(adv))
    else $error("result appeared without a parse step");

  a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_event_kind == K_PAYLOAD) |->
      (out_payload_count == 3'd2 || out_payload_count == 3'd4))
    else $error("payload result with bad count");

  a_error_code_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_event_kind != K_ERROR) |-> (out_error_code == E_NONE))
    else $error("error code on a non-error result");

endmodule
